FILE: design/bmhq_pkg.sv
`timescale 1ns / 1ps
package bmhq_pkg;

	localparam int CAPACITY_DEF     = 64;
	localparam int PAYLOAD_BITS_DEF = 32;
	localparam int SCORE_W          = 32;
	localparam int FIELD_W          = 32;
	localparam int COUNT_W          = 7;

	localparam logic [SCORE_W-1:0] SIGN_BIAS = 32'h8000_0000;

	localparam logic MODE_INS = 1'b0;
	localparam logic MODE_POP = 1'b1;

	localparam logic [1:0] ST_INS   = 2'd0;
	localparam logic [1:0] ST_POP   = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	// wave kinds travelling down the level chain
	typedef enum logic [1:0] {
		OP_PASS,
		OP_INS,
		OP_FETCH,
		OP_DOWN
	} op_kind_t;

	typedef struct packed {
		logic                      mode;
		logic signed [SCORE_W-1:0] score;
		logic [FIELD_W-1:0]        payload;
	} cmd_t;

	typedef struct packed {
		logic [1:0]                status;
		logic signed [SCORE_W-1:0] out_score;
		logic [FIELD_W-1:0]        out_payload;
		logic [COUNT_W-1:0]        count;
	} res_t;

endpackage

FILE: design/bmhq_cell.sv
`timescale 1ns / 1ps
module bmhq_cell #(
	parameter int  LEVEL        = 0,
	parameter int  LEVELS       = 7,
	parameter int  PAYLOAD_BITS = 32,
	parameter type op_t         = logic,
	parameter type wb_t         = logic
) (
	input  logic clk,
	input  logic arst_n,
	input  op_t  op_in,
	output op_t  op_out,
	input  wb_t  wb_in,
	output wb_t  wb_out
);
	import bmhq_pkg::*;

	localparam int LVL_W  = LEVELS - 1;
	localparam int DEP_W  = $clog2(LEVELS);
	localparam int SLOT_W = LEVELS;
	localparam int ROW_W  = (LEVEL > 1) ? LEVEL - 1 : 1;
	localparam int ROWS   = 1 << ROW_W;
	localparam int EW     = SCORE_W + PAYLOAD_BITS;
	localparam logic [SLOT_W-1:0] BASE = SLOT_W'((1 << LEVEL) - 1);

	// sibling pairs of this level: even node in mem_a, odd node in mem_b
	logic [EW-1:0] mem_a [ROWS];
	logic [EW-1:0] mem_b [ROWS];

	logic [EW-1:0]      rd_a_s2, rd_b_s2;
	op_t                op_s2, op_nxt;
	logic [LVL_W-1:0]   in_sh, wr_node, wr_sh, node_adv, dn_node;
	logic [ROW_W-1:0]   rd_row, wr_row;
	logic               wr_en;
	logic [EW-1:0]      wr_data, cur, pk, carried;
	logic [SCORE_W-1:0] a_key, b_key, cur_key;
	logic [SLOT_W-1:0]  left_abs, right_abs;
	logic               at_tgt, l_ok, r_ok, pick_r, mv;

	assign in_sh  = op_in.node >> 1;
	assign rd_row = (op_in.kind == OP_DOWN) ? op_in.node[ROW_W-1:0] : in_sh[ROW_W-1:0];

	assign cur     = op_s2.node[0] ? rd_b_s2 : rd_a_s2;
	assign a_key   = rd_a_s2[EW-1:PAYLOAD_BITS];
	assign b_key   = rd_b_s2[EW-1:PAYLOAD_BITS];
	assign cur_key = cur[EW-1:PAYLOAD_BITS];
	assign carried = {op_s2.ckey, op_s2.ctag};
	assign at_tgt  = (op_s2.depth == DEP_W'(LEVEL));

	assign node_adv = (op_s2.node << 1) | LVL_W'(op_s2.rem[LVL_W-1]);

	// sift-down: children of the hole sit in row op_s2.node of this level
	assign left_abs  = BASE + (SLOT_W'(op_s2.node) << 1);
	assign right_abs = left_abs + SLOT_W'(1);
	assign l_ok      = (left_abs < op_s2.lim);
	assign r_ok      = (right_abs < op_s2.lim);
	assign pick_r    = r_ok && (b_key < a_key);
	assign mv        = l_ok && (pick_r ? (b_key < op_s2.ckey) : (a_key < op_s2.ckey));
	assign pk        = pick_r ? rd_b_s2 : rd_a_s2;
	assign dn_node   = (op_s2.node << 1) | LVL_W'(pick_r);

	assign wr_sh  = wr_node >> 1;
	assign wr_row = wr_sh[ROW_W-1:0];

	always_comb begin
		op_nxt  = op_s2;
		wr_en   = wb_in.vld;
		wr_node = wb_in.node;
		wr_data = {wb_in.key, wb_in.tag};
		wb_out  = '0;
		if (op_s2.vld) begin
			unique case (op_s2.kind)
				OP_INS: begin
					if (at_tgt) begin
						wr_en       = 1'b1;
						wr_node     = op_s2.node;
						wr_data     = carried;
						op_nxt.kind = OP_PASS;
					end else begin
						op_nxt.node = node_adv;
						op_nxt.rem  = op_s2.rem << 1;
						if (op_s2.shift || (op_s2.ckey < cur_key)) begin
							wr_en        = 1'b1;
							wr_node      = op_s2.node;
							wr_data      = carried;
							op_nxt.ckey  = cur_key;
							op_nxt.ctag  = cur[PAYLOAD_BITS-1:0];
							op_nxt.shift = 1'b1;
						end
					end
				end
				OP_FETCH: begin
					if (LEVEL == 0) begin
						op_nxt.rkey = cur_key;
						op_nxt.rtag = cur[PAYLOAD_BITS-1:0];
					end
					if (at_tgt) begin
						op_nxt.ckey = cur_key;
						op_nxt.ctag = cur[PAYLOAD_BITS-1:0];
						op_nxt.kind = OP_PASS;
					end else begin
						op_nxt.node = node_adv;
						op_nxt.rem  = op_s2.rem << 1;
					end
				end
				OP_DOWN: begin
					if (LEVEL == 0) begin
						wr_en   = 1'b1;
						wr_node = op_s2.node;
						wr_data = carried;
					end else if (mv) begin
						// child moves up into the hole, walked entry parks in the child slot
						wr_en       = 1'b1;
						wr_node     = dn_node;
						wr_data     = carried;
						wb_out.vld  = 1'b1;
						wb_out.node = op_s2.node;
						wb_out.key  = pk[EW-1:PAYLOAD_BITS];
						wb_out.tag  = pk[PAYLOAD_BITS-1:0];
						op_nxt.node = dn_node;
					end else begin
						op_nxt.kind = OP_PASS;
					end
				end
				OP_PASS: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_a_s2 <= mem_a[rd_row];
		rd_b_s2 <= mem_b[rd_row];
		if (wr_en) begin
			if (wr_node[0]) begin
				mem_b[wr_row] <= wr_data;
			end else begin
				mem_a[wr_row] <= wr_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s2.vld  <= 1'b0;
			op_out.vld <= 1'b0;
		end else begin
			op_s2  <= op_in;
			op_out <= op_nxt;
		end
	end

endmodule

FILE: design/binary_min_heap_queue.sv
// Item at a time over L = clog2(CAPACITY+1) heap levels (7 for 64 entries); each level
// cell registers a wave at its read stage and again at its output, and a pop runs a fetch
// wave then, unless it takes the last entry, a sift-down wave. A full insert or an empty
// pop skips the chain; a new input is taken only once the result of the last one is
// registered and the controller is idle again.
// Reset clears the entry count and the chain control; heap storage is not cleared.
`timescale 1ns / 1ps
module binary_min_heap_queue #(
	parameter int CAPACITY     = bmhq_pkg::CAPACITY_DEF,
	parameter int PAYLOAD_BITS = bmhq_pkg::PAYLOAD_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  bmhq_pkg::cmd_t  cmd,
	output logic            res_valid,
	input  logic            res_ready,
	output bmhq_pkg::res_t  res
);
	import bmhq_pkg::*;

	localparam int LEVELS = $clog2(CAPACITY + 1);
	localparam int LVL_W  = LEVELS - 1;
	localparam int DEP_W  = $clog2(LEVELS);
	localparam int SLOT_W = LEVELS;

	typedef struct packed {
		logic                    vld;
		op_kind_t                kind;
		logic [LVL_W-1:0]        node;
		logic [LVL_W-1:0]        rem;
		logic [DEP_W-1:0]        depth;
		logic                    shift;
		logic [SLOT_W-1:0]       lim;
		logic [SCORE_W-1:0]      ckey;
		logic [PAYLOAD_BITS-1:0] ctag;
		logic [SCORE_W-1:0]      rkey;
		logic [PAYLOAD_BITS-1:0] rtag;
	} op_t;

	typedef struct packed {
		logic                    vld;
		logic [LVL_W-1:0]        node;
		logic [SCORE_W-1:0]      key;
		logic [PAYLOAD_BITS-1:0] tag;
	} wb_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_FETCH,
		S_DOWN,
		S_DONE
	} state_t;

	state_t                  st_q;
	logic [SLOT_W-1:0]       cnt_q;
	op_t                     launch_q;
	logic                    res_valid_q;
	res_t                    res_q;
	logic [1:0]              pend_status_q;
	logic [SCORE_W-1:0]      pend_key_q;
	logic [PAYLOAD_BITS-1:0] pend_tag_q;

	op_t ops [LEVELS+1];
	wb_t wbs [LEVELS];
	op_t tail, ins_op, fetch_op, down_op;

	logic [SLOT_W-1:0] slot_sel, path_p, path_al;
	logic [DEP_W-1:0]  path_dep;
	logic [LVL_W-1:0]  path_rem;

	assign ops[0]    = launch_q;
	assign tail      = ops[LEVELS];
	assign cmd_ready = (st_q == S_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// root-to-slot path: depth of slot+1 and the bits under its leading one
	always_comb begin
		slot_sel = (cmd.mode == MODE_POP) ? cnt_q - SLOT_W'(1) : cnt_q;
		path_p   = slot_sel + SLOT_W'(1);
		path_dep = '0;
		for (int i = 0; i < SLOT_W; i++) begin
			if (path_p[i]) begin
				path_dep = DEP_W'(i);
			end
		end
		path_al  = path_p << (DEP_W'(LVL_W) - path_dep);
		path_rem = path_al[LVL_W-1:0];
	end

	always_comb begin
		ins_op       = '0;
		ins_op.vld   = 1'b1;
		ins_op.kind  = OP_INS;
		ins_op.rem   = path_rem;
		ins_op.depth = path_dep;
		ins_op.ckey  = $unsigned(cmd.score) ^ SIGN_BIAS;
		ins_op.ctag  = cmd.payload[PAYLOAD_BITS-1:0];

		fetch_op       = '0;
		fetch_op.vld   = 1'b1;
		fetch_op.kind  = OP_FETCH;
		fetch_op.rem   = path_rem;
		fetch_op.depth = path_dep;

		down_op      = '0;
		down_op.vld  = 1'b1;
		down_op.kind = OP_DOWN;
		down_op.lim  = cnt_q - SLOT_W'(1);
		down_op.ckey = tail.ckey;
		down_op.ctag = tail.ctag;
	end

	for (genvar g = 0; g < LEVELS; g++) begin : g_lvl
		wb_t wb_next;
		if (g == LEVELS - 1) begin : g_last
			assign wb_next = '0;
		end else begin : g_mid
			assign wb_next = wbs[g+1];
		end
		bmhq_cell #(
			.LEVEL        (g),
			.LEVELS       (LEVELS),
			.PAYLOAD_BITS (PAYLOAD_BITS),
			.op_t         (op_t),
			.wb_t         (wb_t)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.op_in  (ops[g]),
			.op_out (ops[g+1]),
			.wb_in  (wb_next),
			.wb_out (wbs[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_IDLE;
			cnt_q        <= '0;
			launch_q.vld <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (res_valid_q && res_ready && st_q != S_DONE) begin
				res_valid_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (cmd_valid) begin
						if (cmd.mode == MODE_INS) begin
							if (cnt_q >= SLOT_W'(CAPACITY)) begin
								pend_status_q <= ST_FULL;
								st_q          <= S_DONE;
							end else begin
								launch_q      <= ins_op;
								cnt_q         <= cnt_q + SLOT_W'(1);
								pend_status_q <= ST_INS;
								st_q          <= S_INS;
							end
						end else if (cnt_q == '0) begin
							pend_status_q <= ST_EMPTY;
							st_q          <= S_DONE;
						end else begin
							launch_q      <= fetch_op;
							pend_status_q <= ST_POP;
							st_q          <= S_FETCH;
						end
					end
				end
				S_INS, S_DOWN: begin
					launch_q.vld <= 1'b0;
					if (tail.vld) begin
						st_q <= S_DONE;
					end
				end
				S_FETCH: begin
					if (tail.vld) begin
						pend_key_q <= tail.rkey;
						pend_tag_q <= tail.rtag;
						cnt_q      <= cnt_q - SLOT_W'(1);
						if (cnt_q == SLOT_W'(1)) begin
							st_q <= S_DONE;
						end else begin
							launch_q <= down_op;
							st_q     <= S_DOWN;
						end
					end else begin
						launch_q.vld <= 1'b0;
					end
				end
				S_DONE: begin
					if (!res_valid_q || res_ready) begin
						res_q.status      <= pend_status_q;
						res_q.out_score   <= (pend_status_q == ST_POP) ?
							signed'(pend_key_q ^ SIGN_BIAS) : '0;
						res_q.out_payload <= (pend_status_q == ST_POP) ?
							FIELD_W'(pend_tag_q) : '0;
						res_q.count       <= COUNT_W'(cnt_q);
						res_valid_q       <= 1'b1;
						st_q              <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	a_tail_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tail.vld |-> (st_q == S_INS || st_q == S_FETCH || st_q == S_DOWN))
		else $error("wave left the chain while no operation was pending");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= SLOT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_no_launch_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_IDLE || st_q == S_DONE) |-> !launch_q.vld)
		else $error("wave launched outside an operation");

	a_res_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status != ST_POP) |-> (res.out_score == '0 && res.out_payload == '0))
		else $error("non-pop transfer carries entry data");

	a_wb_root: assert property (@(posedge clk) disable iff (!arst_n)
		tail.vld |=> !tail.vld)
		else $error("wave token lasted more than one cycle");

endmodule

FILE: bench/binary_min_heap_queue_tb.sv
`timescale 1ns / 1ps
module binary_min_heap_queue_tb;
	import bmhq_pkg::*;

	localparam int CAP        = CAPACITY_DEF;
	localparam int N_RANDOM   = 1630;
	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN      = 48;
	localparam int HOLD_LEN   = 400;
	localparam logic [FIELD_W-1:0] TAG_MASK = FIELD_W'((64'd1 << PAYLOAD_BITS_DEF) - 1);

	typedef struct {
		cmd_t c;
		bit   known;
		res_t want;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;
	logic res_valid;
	logic res_ready;
	res_t res;

	binary_min_heap_queue u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	// predictor state: min-heap of scores with tags
	logic signed [SCORE_W-1:0] heap_score [CAP];
	logic [FIELD_W-1:0]        heap_tag [CAP];
	int                        heap_n;

	res_t      queue_answers[$];
	plan_row_t plan[$];
	int        mismatches;
	int        idle_cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic res_t heap_apply(cmd_t c);
		res_t                      r;
		int                        pos;
		int                        parent;
		int                        left;
		int                        pick;
		logic signed [SCORE_W-1:0] key;
		logic [FIELD_W-1:0]        tag;
		r = '0;
		if (c.mode == MODE_INS) begin
			if (heap_n >= CAP) begin
				r.status = ST_FULL;
			end else begin
				key = c.score;
				tag = c.payload & TAG_MASK;
				pos = heap_n;
				heap_n++;
				while (pos > 0) begin
					parent = (pos - 1) / 2;
					if (key < heap_score[parent]) begin
						heap_score[pos] = heap_score[parent];
						heap_tag[pos]   = heap_tag[parent];
						pos = parent;
					end else begin
						break;
					end
				end
				heap_score[pos] = key;
				heap_tag[pos]   = tag;
				r.status = ST_INS;
			end
		end else begin
			if (heap_n == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.status      = ST_POP;
				r.out_score   = heap_score[0];
				r.out_payload = heap_tag[0];
				heap_n--;
				if (heap_n > 0) begin
					key = heap_score[heap_n];
					tag = heap_tag[heap_n];
					pos = 0;
					forever begin
						left = 2 * pos + 1;
						if (left >= heap_n)
							break;
						pick = left;
						if (left + 1 < heap_n && heap_score[left + 1] < heap_score[left])
							pick = left + 1;
						if (heap_score[pick] < key) begin
							heap_score[pos] = heap_score[pick];
							heap_tag[pos]   = heap_tag[pick];
							pos = pick;
						end else begin
							break;
						end
					end
					heap_score[pos] = key;
					heap_tag[pos]   = tag;
				end
			end
		end
		r.count = COUNT_W'(heap_n);
		return r;
	endfunction

	function automatic void flag_mismatch(string what);
		if (mismatches < 10)
			$display("mismatch @%0t: %s", $time, what);
		mismatches++;
	endfunction

	function automatic void plan_add(logic mode, logic [SCORE_W-1:0] s, logic [FIELD_W-1:0] p,
			bit known, logic [1:0] st, logic [SCORE_W-1:0] os, logic [FIELD_W-1:0] op,
			int cnt);
		plan_row_t row;
		row.c.mode            = mode;
		row.c.score           = s;
		row.c.payload         = p;
		row.known             = known;
		row.want.status       = st;
		row.want.out_score    = os;
		row.want.out_payload  = op;
		row.want.count        = COUNT_W'(cnt);
		plan.push_back(row);
	endfunction

	function automatic logic [SCORE_W-1:0] pick_score();
		int sel;
		sel = $urandom_range(15);
		if (sel < 4)
			return SCORE_W'($signed($urandom_range(6)) - 3);
		if (sel == 4)
			return 32'h7FFF_FFFF;
		if (sel == 5)
			return 32'h8000_0000;
		return $urandom;
	endfunction

	// sender: optional gap, then hold valid until the transfer
	bit send_calm;
	task automatic send_cmd(cmd_t c, bit known, res_t want);
		int   gap;
		res_t predicted;
		if ($urandom_range(40) == 0)
			send_calm = !send_calm;
		gap = send_calm ? 0 : $urandom_range(16);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		do @(posedge clk); while (!cmd_ready);
		predicted = heap_apply(c);
		queue_answers.push_back(known ? want : predicted);
	endtask

	// receiver; long holds at two points of the run stall the block
	initial begin
		int   stall;
		int   rx_n;
		bit   calm;
		res_t exp_r;
		res_ready = 1'b0;
		calm      = 1'b0;
		rx_n      = 0;
		@(posedge arst_n);
		forever begin
			if (rx_n == 520 || rx_n == 1120) begin
				stall = HOLD_LEN;
			end else begin
				if ($urandom_range(40) == 0)
					calm = !calm;
				stall = calm ? 0 : $urandom_range(16);
			end
			if (stall > 0) begin
				res_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ready <= 1'b1;
			do @(posedge clk); while (!res_valid);
			rx_n++;
			if (queue_answers.size() == 0) begin
				flag_mismatch($sformatf("unexpected result %p", res));
			end else begin
				exp_r = queue_answers.pop_front();
				if (res.status !== exp_r.status)
					flag_mismatch($sformatf("status exp %0d got %0d", exp_r.status, res.status));
				if (res.out_score !== exp_r.out_score)
					flag_mismatch($sformatf("out_score exp %0d got %0d",
						exp_r.out_score, res.out_score));
				if (res.out_payload !== exp_r.out_payload)
					flag_mismatch($sformatf("out_payload exp %h got %h",
						exp_r.out_payload, res.out_payload));
				if (res.count !== exp_r.count)
					flag_mismatch($sformatf("count exp %0d got %0d", exp_r.count, res.count));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && cmd_ready) || (res_valid && res_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		cmd_t c;
		int   ins_pct;
		int   seg_left;
		int   pcts[3];
		arst_n      = 1'b0;
		cmd_valid   = 1'b0;
		cmd         = '0;
		heap_n      = 0;
		mismatches  = 0;
		send_calm   = 1'b0;
		pcts        = '{95, 50, 15};

		plan_add(MODE_POP, 0, 0, 1, ST_EMPTY, 0, 0, 0);
		plan_add(MODE_INS, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, ST_INS, 0, 0, 1);
		plan_add(MODE_INS, 32'h8000_0000, 32'h0000_0000, 1, ST_INS, 0, 0, 2);
		plan_add(MODE_INS, 0, 32'hA5A5_A5A5, 1, ST_INS, 0, 0, 3);
		plan_add(MODE_INS, -1, 32'h5A5A_5A5A, 1, ST_INS, 0, 0, 4);
		plan_add(MODE_POP, -1, 32'hFFFF_FFFF, 1, ST_POP, 32'h8000_0000, 0, 3);
		plan_add(MODE_INS, 5, 1, 0, '0, 0, 0, 0);
		plan_add(MODE_INS, 5, 2, 0, '0, 0, 0, 0);
		plan_add(MODE_INS, 5, 3, 0, '0, 0, 0, 0);
		plan_add(MODE_POP, 32'h1234_5678, 32'h8765_4321, 1, ST_POP, -1, 32'h5A5A_5A5A, 5);
		repeat (5)
			plan_add(MODE_POP, 0, 0, 0, '0, 0, 0, 0);
		plan_add(MODE_POP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ST_EMPTY, 0, 0, 0);
		plan_add(MODE_INS, 7, 32'h1234_5678, 0, '0, 0, 0, 0);
		plan_add(MODE_INS, 7, 32'h0BAD_F00D, 0, '0, 0, 0, 0);
		plan_add(MODE_INS, 3, 32'hFFFF_0000, 0, '0, 0, 0, 0);
		plan_add(MODE_INS, 32'h8000_0000, 32'h0000_FFFF, 0, '0, 0, 0, 0);
		repeat (4)
			plan_add(MODE_POP, 0, 0, 0, '0, 0, 0, 0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			send_cmd(plan[i].c, plan[i].known, plan[i].want);

		// segments lean toward inserts, pops or neither so the heap runs full and empty
		ins_pct  = pcts[0];
		seg_left = 90;
		for (int n = 0; n < N_RANDOM; n++) begin
			if (seg_left == 0) begin
				ins_pct  = pcts[$urandom_range(2)];
				seg_left = $urandom_range(90, 30);
			end
			seg_left--;
			c.mode    = ($urandom_range(99) < ins_pct) ? MODE_INS : MODE_POP;
			c.score   = pick_score();
			c.payload = $urandom;
			send_cmd(c, 1'b0, '0);
		end
		cmd_valid <= 1'b0;

		while (queue_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (queue_answers.size() != 0)
			flag_mismatch("results still outstanding");

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: files.f
design/bmhq_pkg.sv
design/bmhq_cell.sv
design/binary_min_heap_queue.sv
bench/binary_min_heap_queue_tb.sv
